/* src/atkt_pkg.sv */
// ----------------------------------------------------------------------------
// atkt_pkg
// Shared types and constants of the access tag/key table: operation codes,
// the query broadcast to the cells, the probe handed along the cell chain
// and the write command.
// ----------------------------------------------------------------------------
package atkt_pkg;

    localparam int TAG_W       = 32;
    localparam int KEY_W       = 32;
    localparam int SLOT_W      = 4;
    localparam int ACT_W       = 5;
    localparam int ENTRY_IDX_W = 8;

    localparam logic [TAG_W-1:0] EMPTY_TAG = 32'h0000_0000;
    localparam logic [ACT_W-1:0] NO_SLOT   = 5'h1F;

    typedef enum logic [2:0] {
        OP_SEARCH   = 3'd0,
        OP_CREATE   = 3'd1,
        OP_DEL_SLOT = 3'd2,
        OP_DEL_TAG  = 3'd3,
        OP_DEL_ALL  = 3'd4,
        OP_READ     = 3'd5,
        OP_CHECK    = 3'd6,
        OP_NONE     = 3'd7
    } op_t;

    typedef struct packed {
        logic [TAG_W-1:0]       tag;
        logic [KEY_W-1:0]       key;
        logic [ENTRY_IDX_W-1:0] slot;
        logic                   act_valid;
        logic [ENTRY_IDX_W-1:0] act_idx;
    } query_t;

    typedef struct packed {
        logic                   valid;
        logic                   hit;
        logic [ENTRY_IDX_W-1:0] hit_idx;
        logic                   empty;
        logic [ENTRY_IDX_W-1:0] empty_idx;
        logic [TAG_W-1:0]       rd_tag;
        logic [KEY_W-1:0]       rd_key;
        logic                   key_eq;
    } probe_t;

    typedef struct packed {
        logic                   en;
        logic                   clr_all;
        logic [ENTRY_IDX_W-1:0] idx;
        logic [TAG_W-1:0]       tag;
        logic [KEY_W-1:0]       key;
    } write_t;

endpackage

/* src/atkt_if.sv */
// ----------------------------------------------------------------------------
// atkt_req_if / atkt_rsp_if
// Valid/ready channels carrying one operation beat and one result beat.
// ----------------------------------------------------------------------------
interface atkt_req_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     op;
    logic [atkt_pkg::TAG_W-1:0]     tag_code;
    logic [atkt_pkg::KEY_W-1:0]     key_code;
    logic [atkt_pkg::SLOT_W-1:0]    slot_index;

    modport source (output valid, op, tag_code, key_code, slot_index, input ready);
    modport sink   (input valid, op, tag_code, key_code, slot_index, output ready);
endinterface

interface atkt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               success;
    logic signed [atkt_pkg::ACT_W-1:0]  active_slot_out;
    logic [atkt_pkg::TAG_W-1:0]         tag_out;
    logic [atkt_pkg::KEY_W-1:0]         key_out;

    modport source (output valid, success, active_slot_out, tag_out, key_out, input ready);
    modport sink   (input valid, success, active_slot_out, tag_out, key_out, output ready);
endinterface

/* src/atkt_cell.sv */
// ----------------------------------------------------------------------------
// atkt_cell
// One table entry. It holds a tag and a key, folds its own entry into the
// probe passing by and registers the probe for the next cell.
// ----------------------------------------------------------------------------
module atkt_cell #(
    parameter int INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  atkt_pkg::query_t  query,
    input  atkt_pkg::write_t  wr,
    input  atkt_pkg::probe_t  probe_in,
    output atkt_pkg::probe_t  probe_out
);

    localparam logic [atkt_pkg::ENTRY_IDX_W-1:0] OWN = atkt_pkg::ENTRY_IDX_W'(INDEX);

    logic [atkt_pkg::TAG_W-1:0] tag_reg;
    logic [atkt_pkg::KEY_W-1:0] key_reg;
    atkt_pkg::probe_t           probe_reg;
    atkt_pkg::probe_t           probe_next;

    always_comb
    begin
        probe_next = probe_in;
        if (!probe_in.hit && query.tag != atkt_pkg::EMPTY_TAG && tag_reg == query.tag)
        begin
            probe_next.hit     = 1'b1;
            probe_next.hit_idx = OWN;
        end
        if (!probe_in.empty && tag_reg == atkt_pkg::EMPTY_TAG)
        begin
            probe_next.empty     = 1'b1;
            probe_next.empty_idx = OWN;
        end
        if (query.slot == OWN)
        begin
            probe_next.rd_tag = tag_reg;
            probe_next.rd_key = key_reg;
        end
        if (query.act_valid && query.act_idx == OWN)
        begin
            probe_next.key_eq = (key_reg == query.key);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= atkt_pkg::EMPTY_TAG;
            key_reg   <= '0;
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (wr.clr_all)
            begin
                tag_reg <= atkt_pkg::EMPTY_TAG;
                key_reg <= '0;
            end
            else if (wr.en && wr.idx == OWN)
            begin
                tag_reg <= wr.tag;
                key_reg <= wr.key;
            end
        end
    end

    assign probe_out = probe_reg;

endmodule

/* src/access_tag_key_table.sv */
// ----------------------------------------------------------------------------
// access_tag_key_table
// Table of access entries (tag and key) with an active slot, built as a
// chain of entry cells that a probe walks one cell per cycle.
//
// Usage: operations arrive as beats on req (op, tag_code, key_code,
// slot_index) and each yields exactly one result beat on rsp (success,
// active_slot_out, tag_out, key_out). One operation is worked on at a time;
// req.ready is high while the controller is idle, even when a result still
// waits on rsp.
// Timing: an operation's probe walks the whole cell chain, is captured at its
// end and then loaded into the output register as the result beat; no new
// operation is accepted until that result has been loaded.
// Reset: every entry is cleared to the empty tag and zero key, the active
// slot is none, and no result is pending.
// Stall: when rsp is stalled the finished result holds the controller; the
// table is updated only when the result beat is loaded into the output
// register, and the beat stays stable until it is taken.
// ----------------------------------------------------------------------------
module access_tag_key_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    atkt_req_if.sink        req,
    atkt_rsp_if.source      rsp
);

    localparam int IW = atkt_pkg::ENTRY_IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    state_t                      state_reg;
    atkt_pkg::op_t               op_reg;
    logic [atkt_pkg::TAG_W-1:0]  tag_reg;
    logic [atkt_pkg::KEY_W-1:0]  key_reg;
    logic [IW-1:0]               slot_reg;
    logic                        slot_ok_reg;
    logic                        start_reg;
    atkt_pkg::probe_t            res_reg;
    logic                        act_valid_reg;
    logic [IW-1:0]               act_idx_reg;

    logic                        rsp_valid_reg;
    logic                        success_reg;
    logic [atkt_pkg::ACT_W-1:0]  act_out_reg;
    logic [atkt_pkg::TAG_W-1:0]  tag_out_reg;
    logic [atkt_pkg::KEY_W-1:0]  key_out_reg;

    atkt_pkg::query_t            query;
    atkt_pkg::write_t            wr;
    atkt_pkg::probe_t            chain [0:TABLE_ENTRIES];

    logic                        load;
    logic                        ok;
    logic                        act_valid_next;
    logic [IW-1:0]               act_idx_next;
    logic [atkt_pkg::TAG_W-1:0]  tag_o;
    logic [atkt_pkg::KEY_W-1:0]  key_o;

    assign query.tag       = tag_reg;
    assign query.key       = key_reg;
    assign query.slot      = slot_reg;
    assign query.act_valid = act_valid_reg;
    assign query.act_idx   = act_idx_reg;

    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = start_reg;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        atkt_cell #(
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .query     (query),
            .wr        (wr),
            .probe_in  (chain[i]),
            .probe_out (chain[i+1])
        );
    end

    assign load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        wr             = '0;
        ok             = 1'b0;
        act_valid_next = act_valid_reg;
        act_idx_next   = act_idx_reg;
        tag_o          = '0;
        key_o          = '0;
        case (op_reg)
            atkt_pkg::OP_SEARCH:
            begin
                act_valid_next = res_reg.hit;
                act_idx_next   = res_reg.hit_idx;
                ok             = res_reg.hit;
            end
            atkt_pkg::OP_CREATE:
            begin
                if (tag_reg != atkt_pkg::EMPTY_TAG && (res_reg.hit || res_reg.empty))
                begin
                    wr.en          = 1'b1;
                    wr.idx         = res_reg.hit ? res_reg.hit_idx : res_reg.empty_idx;
                    wr.tag         = tag_reg;
                    wr.key         = key_reg;
                    act_valid_next = 1'b1;
                    act_idx_next   = wr.idx;
                    ok             = 1'b1;
                end
            end
            atkt_pkg::OP_DEL_SLOT:
            begin
                if (slot_ok_reg)
                begin
                    wr.en  = 1'b1;
                    wr.idx = slot_reg;
                    ok     = 1'b1;
                end
            end
            atkt_pkg::OP_DEL_TAG:
            begin
                act_valid_next = res_reg.hit;
                act_idx_next   = res_reg.hit_idx;
                if (res_reg.hit)
                begin
                    wr.en  = 1'b1;
                    wr.idx = res_reg.hit_idx;
                    ok     = 1'b1;
                end
            end
            atkt_pkg::OP_DEL_ALL:
            begin
                wr.clr_all = 1'b1;
                ok         = 1'b1;
            end
            atkt_pkg::OP_READ:
            begin
                if (slot_ok_reg)
                begin
                    tag_o = res_reg.rd_tag;
                    key_o = res_reg.rd_key;
                    ok    = 1'b1;
                end
            end
            atkt_pkg::OP_CHECK:
            begin
                ok = act_valid_reg && res_reg.key_eq;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        if (!load)
        begin
            wr = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            act_valid_reg <= 1'b0;
            act_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (rsp_valid_reg && rsp.ready && !load)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg      <= atkt_pkg::op_t'(req.op);
                        tag_reg     <= req.tag_code;
                        key_reg     <= req.key_code;
                        slot_reg    <= IW'({{IW{1'b0}}, req.slot_index});
                        slot_ok_reg <= {{(32-atkt_pkg::SLOT_W){1'b0}}, req.slot_index}
                                       < 32'(TABLE_ENTRIES);
                        start_reg   <= 1'b1;
                        state_reg   <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (chain[TABLE_ENTRIES].valid)
                    begin
                        res_reg   <= chain[TABLE_ENTRIES];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load)
                    begin
                        act_valid_reg <= act_valid_next;
                        act_idx_reg   <= act_idx_next;
                        rsp_valid_reg <= 1'b1;
                        success_reg   <= ok;
                        act_out_reg   <= act_valid_next
                                         ? atkt_pkg::ACT_W'({{atkt_pkg::ACT_W{1'b0}}, act_idx_next})
                                         : atkt_pkg::NO_SLOT;
                        tag_out_reg   <= tag_o;
                        key_out_reg   <= key_o;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.success         = success_reg;
    assign rsp.active_slot_out = act_out_reg;
    assign rsp.tag_out         = tag_out_reg;
    assign rsp.key_out         = key_out_reg;

endmodule

/* tb/access_tag_key_table_tb.sv */
// ----------------------------------------------------------------------------
// access_tag_key_table_tb
// Self-checking bench for the access tag/key table. A short table of directed
// operations covers the extremes, every opcode, the zero tag and the unused
// opcode. A long random run follows, drawing tags from a small pool so the
// table fills, empties and overflows. Every result beat is checked against a
// local copy of the table that is updated as each operation is accepted.
// Both channels idle at random. One long receiver stall backs the block up.
// ----------------------------------------------------------------------------
module access_tag_key_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES       = 16;
    localparam int RANDOM_OPS    = 1750;
    localparam int POOL_SIZE     = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int DIRECTED_ROWS = 25;

    localparam int TAG_W  = atkt_pkg::TAG_W;
    localparam int KEY_W  = atkt_pkg::KEY_W;
    localparam int SLOT_W = atkt_pkg::SLOT_W;
    localparam int ACT_W  = atkt_pkg::ACT_W;

    localparam logic [TAG_W-1:0] EMPTY_TAG = atkt_pkg::EMPTY_TAG;
    localparam logic [ACT_W-1:0] NO_SLOT   = atkt_pkg::NO_SLOT;

    typedef atkt_pkg::op_t op_t;

    typedef struct packed {
        logic             success;
        logic [ACT_W-1:0] act;
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } result_t;

    typedef struct packed {
        op_t               op;
        logic [TAG_W-1:0]  tag;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
        logic              typed;
        result_t           want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{atkt_pkg::OP_SEARCH,   32'h0000_0001, 32'h0000_0000, 4'd0,  1'b1,
            '{1'b0, NO_SLOT, 32'h0, 32'h0}},
        '{atkt_pkg::OP_CHECK,    32'h0000_0000, 32'h0000_0000, 4'd0,  1'b1,
            '{1'b0, NO_SLOT, 32'h0, 32'h0}},
        '{atkt_pkg::OP_READ,     32'h0000_0000, 32'h0000_0000, 4'd0,  1'b1,
            '{1'b1, NO_SLOT, 32'h0, 32'h0}},
        '{atkt_pkg::OP_READ,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1,
            '{1'b1, NO_SLOT, 32'h0, 32'h0}},
        '{atkt_pkg::OP_CREATE,   32'h0000_0000, 32'hDEAD_BEEF, 4'd0,  1'b1,
            '{1'b0, NO_SLOT, 32'h0, 32'h0}},
        '{atkt_pkg::OP_NONE,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1,
            '{1'b0, NO_SLOT, 32'h0, 32'h0}},
        '{atkt_pkg::OP_CREATE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0,  1'b1,
            '{1'b1, 5'd0,    32'h0, 32'h0}},
        '{atkt_pkg::OP_CREATE,   32'h0000_0001, 32'h0000_0000, 4'd0,  1'b1,
            '{1'b1, 5'd1,    32'h0, 32'h0}},
        '{atkt_pkg::OP_CREATE,   32'h8000_0000, 32'h1234_5678, 4'd0,  1'b1,
            '{1'b1, 5'd2,    32'h0, 32'h0}},
        '{atkt_pkg::OP_CREATE,   32'hFFFF_FFFF, 32'h5555_AAAA, 4'd0,  1'b1,
            '{1'b1, 5'd0,    32'h0, 32'h0}},
        '{atkt_pkg::OP_READ,     32'h0000_0000, 32'h0000_0000, 4'd0,  1'b1,
            '{1'b1, 5'd0, 32'hFFFF_FFFF, 32'h5555_AAAA}},
        '{atkt_pkg::OP_CHECK,    32'h0000_0000, 32'h5555_AAAA, 4'd0,  1'b1,
            '{1'b1, 5'd0,    32'h0, 32'h0}},
        '{atkt_pkg::OP_CHECK,    32'h0000_0000, 32'h0000_0000, 4'd0,  1'b1,
            '{1'b0, 5'd0,    32'h0, 32'h0}},
        '{atkt_pkg::OP_SEARCH,   32'h0000_0001, 32'h0000_0000, 4'd0,  1'b1,
            '{1'b1, 5'd1,    32'h0, 32'h0}},
        '{atkt_pkg::OP_SEARCH,   32'h0000_0000, 32'h0000_0000, 4'd0,  1'b1,
            '{1'b0, NO_SLOT, 32'h0, 32'h0}},
        '{atkt_pkg::OP_SEARCH,   32'h8000_0000, 32'h0000_0000, 4'd0,  1'b1,
            '{1'b1, 5'd2,    32'h0, 32'h0}},
        '{atkt_pkg::OP_DEL_TAG,  32'h8000_0000, 32'h0000_0000, 4'd0,  1'b1,
            '{1'b1, 5'd2,    32'h0, 32'h0}},
        '{atkt_pkg::OP_CHECK,    32'h0000_0000, 32'h0000_0000, 4'd0,  1'b0, '0},
        '{atkt_pkg::OP_DEL_TAG,  32'h0000_0000, 32'h0000_0000, 4'd0,  1'b1,
            '{1'b0, NO_SLOT, 32'h0, 32'h0}},
        '{atkt_pkg::OP_DEL_SLOT, 32'h0000_0000, 32'h0000_0000, 4'd15, 1'b1,
            '{1'b1, NO_SLOT, 32'h0, 32'h0}},
        '{atkt_pkg::OP_DEL_SLOT, 32'h0000_0000, 32'h0000_0000, 4'd0,  1'b1,
            '{1'b1, NO_SLOT, 32'h0, 32'h0}},
        '{atkt_pkg::OP_CREATE,   32'hAAAA_5555, 32'h0F0F_F0F0, 4'd0,  1'b0, '0},
        '{atkt_pkg::OP_READ,     32'h0000_0000, 32'h0000_0000, 4'd0,  1'b0, '0},
        '{atkt_pkg::OP_DEL_ALL,  32'h0000_0000, 32'h0000_0000, 4'd0,  1'b0, '0},
        '{atkt_pkg::OP_READ,     32'h0000_0000, 32'h0000_0000, 4'd1,  1'b0, '0}
    };

    logic clk;
    logic rst_n;

    atkt_req_if req_if ();
    atkt_rsp_if rsp_if ();

    access_tag_key_table #(
        .TABLE_ENTRIES(ENTRIES)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if)
    );

    logic [TAG_W-1:0] tbl_tag [ENTRIES];
    logic [KEY_W-1:0] tbl_key [ENTRIES];
    logic [ACT_W-1:0] tbl_act;

    result_t          op_results_due [$];
    logic [TAG_W-1:0] tag_pool [POOL_SIZE];
    int               fail_count;
    bit               calm;
    bit               hold_off_req;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [ACT_W-1:0] lowest_slot_of(input logic [TAG_W-1:0] tag);
        if (tag == EMPTY_TAG)
        begin
            return NO_SLOT;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_tag[i] == tag)
            begin
                return ACT_W'(i);
            end
        end
        return NO_SLOT;
    endfunction

    function automatic result_t apply_table_op(input op_t op, input logic [TAG_W-1:0] tag,
                                               input logic [KEY_W-1:0] key,
                                               input logic [SLOT_W-1:0] slot);
        result_t          r;
        logic [ACT_W-1:0] hit;
        r = '0;
        case (op)
            atkt_pkg::OP_SEARCH:
            begin
                tbl_act   = lowest_slot_of(tag);
                r.success = (tbl_act != NO_SLOT);
            end
            atkt_pkg::OP_CREATE:
            begin
                if (tag != EMPTY_TAG)
                begin
                    hit = lowest_slot_of(tag);
                    if (hit == NO_SLOT)
                    begin
                        for (int i = ENTRIES - 1; i >= 0; i--)
                        begin
                            if (tbl_tag[i] == EMPTY_TAG)
                            begin
                                hit = ACT_W'(i);
                            end
                        end
                    end
                    if (hit != NO_SLOT)
                    begin
                        tbl_tag[hit[SLOT_W-1:0]] = tag;
                        tbl_key[hit[SLOT_W-1:0]] = key;
                        tbl_act   = hit;
                        r.success = 1'b1;
                    end
                end
            end
            atkt_pkg::OP_DEL_SLOT:
            begin
                tbl_tag[slot] = EMPTY_TAG;
                tbl_key[slot] = '0;
                r.success     = 1'b1;
            end
            atkt_pkg::OP_DEL_TAG:
            begin
                tbl_act = lowest_slot_of(tag);
                if (tbl_act != NO_SLOT)
                begin
                    tbl_tag[tbl_act[SLOT_W-1:0]] = EMPTY_TAG;
                    tbl_key[tbl_act[SLOT_W-1:0]] = '0;
                    r.success = 1'b1;
                end
            end
            atkt_pkg::OP_DEL_ALL:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    tbl_tag[i] = EMPTY_TAG;
                    tbl_key[i] = '0;
                end
                r.success = 1'b1;
            end
            atkt_pkg::OP_READ:
            begin
                r.tag     = tbl_tag[slot];
                r.key     = tbl_key[slot];
                r.success = 1'b1;
            end
            atkt_pkg::OP_CHECK:
            begin
                r.success = (tbl_act != NO_SLOT) && (tbl_key[tbl_act[SLOT_W-1:0]] == key);
            end
            default:
            begin
            end
        endcase
        r.act = tbl_act;
        return r;
    endfunction

    task automatic send_op(input op_t op, input logic [TAG_W-1:0] tag,
                           input logic [KEY_W-1:0] key, input logic [SLOT_W-1:0] slot,
                           input logic typed, input result_t want);
        result_t predicted;
        if (!calm && $urandom_range(99) < 30)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= op;
        req_if.tag_code   <= tag;
        req_if.key_code   <= key;
        req_if.slot_index <= slot;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        predicted = apply_table_op(op, tag, key, slot);
        op_results_due.push_back(typed ? want : predicted);
    endtask

    function automatic logic [TAG_W-1:0] pick_tag();
        int w;
        w = $urandom_range(99);
        if (w < 5)
        begin
            return EMPTY_TAG;
        end
        if (w < 15)
        begin
            return $urandom;
        end
        return tag_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    initial
    begin
        #5_000_000;
        $display("access_tag_key_table_tb: errors");
        $finish;
    end

    initial
    begin
        result_t want;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (op_results_due.size() == 0)
                begin
                    $error("result beat arrived with no operation outstanding");
                    fail_count++;
                end
                else
                begin
                    want = op_results_due.pop_front();
                    if (rsp_if.success !== want.success)
                    begin
                        $error("success: expected %0d, actual %0d", want.success,
                               rsp_if.success);
                        fail_count++;
                    end
                    if (rsp_if.active_slot_out !== want.act)
                    begin
                        $error("active_slot_out: expected %0d, actual %0d",
                               $signed(want.act), rsp_if.active_slot_out);
                        fail_count++;
                    end
                    if (rsp_if.tag_out !== want.tag)
                    begin
                        $error("tag_out: expected %h, actual %h", want.tag, rsp_if.tag_out);
                        fail_count++;
                    end
                    if (rsp_if.key_out !== want.key)
                    begin
                        $error("key_out: expected %h, actual %h", want.key, rsp_if.key_out);
                        fail_count++;
                    end
                end
            end
            if (hold_off_req)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            rsp_if.ready <= calm || ($urandom_range(99) >= 30);
        end
    end

    initial
    begin
        int               sent;
        int               w;
        op_t              op;
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
        fail_count   = 0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.op          <= atkt_pkg::OP_NONE;
        req_if.tag_code    <= '0;
        req_if.key_code    <= '0;
        req_if.slot_index  <= '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_tag[i] = EMPTY_TAG;
            tbl_key[i] = '0;
        end
        tbl_act = NO_SLOT;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            tag_pool[i] = $urandom;
        end
        tag_pool[0] = 32'hFFFF_FFFF;
        tag_pool[1] = 32'h0000_0001;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_op(DIRECTED[i].op, DIRECTED[i].tag, DIRECTED[i].key, DIRECTED[i].slot,
                    DIRECTED[i].typed, DIRECTED[i].want);
        end

        sent = 0;
        while (sent < RANDOM_OPS)
        begin
            calm = (sent >= 600 && sent < 900);
            if (sent == 1200)
            begin
                hold_off_req = 1'b1;
            end
            w   = $urandom_range(99);
            tag = pick_tag();
            key = $urandom;
            if (w < 28)
            begin
                op = atkt_pkg::OP_CREATE;
            end
            else if (w < 42)
            begin
                op = atkt_pkg::OP_SEARCH;
            end
            else if (w < 52)
            begin
                op = atkt_pkg::OP_DEL_TAG;
            end
            else if (w < 60)
            begin
                op = atkt_pkg::OP_DEL_SLOT;
            end
            else if (w < 74)
            begin
                op = atkt_pkg::OP_READ;
            end
            else if (w < 92)
            begin
                op = atkt_pkg::OP_CHECK;
                if (tbl_act != NO_SLOT && $urandom_range(1) == 1)
                begin
                    key = tbl_key[tbl_act[SLOT_W-1:0]];
                end
            end
            else if (w < 95)
            begin
                op = atkt_pkg::OP_DEL_ALL;
            end
            else
            begin
                op = atkt_pkg::OP_NONE;
            end
            send_op(op, tag, key, SLOT_W'($urandom_range(ENTRIES - 1)), 1'b0, '0);
            if (op != atkt_pkg::OP_NONE)
            begin
                sent++;
            end
        end
        req_if.valid <= 1'b0;

        while (op_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("access_tag_key_table_tb: clean");
        end
        else
        begin
            $display("access_tag_key_table_tb: errors");
        end
        $finish;
    end

endmodule
